[rtl/atni_pkg.sv]
// Shared types and constants for the ADC-to-oscillator-increment unit.
// Used by every module under rtl; depends on nothing.
package atni_pkg;

  localparam int ADC_BITS_DEF   = 10;
  localparam int DIV_BITS       = 32;
  localparam int STEPS_PER_STG  = 4;
  localparam int DIV_STAGES     = DIV_BITS / STEPS_PER_STG;
  localparam int INC_SHIFT      = 21;
  localparam int PRE_BITS       = DIV_BITS - INC_SHIFT;
  localparam logic [31:0] DEAD_LOW  = 32'd500;
  localparam logic [31:0] DEAD_HIGH = 32'd524;
  localparam logic [31:0] CLK_RESET = 32'd32000000;
  localparam int ADDR_BITS = 4;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_STOP  = 2'd1,
    REG_CLOCK = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] freq;
  } freq_item_t;

  typedef struct packed {
    logic        vld;
    logic        ovf;
    logic [31:0] freq;
    logic [31:0] rem;
    logic [31:0] sh;
    logic [31:0] quo;
  } div_item_t;

endpackage

[rtl/adc_to_nco_increment_unit.sv]
// Top level: APB registers, frequency selection, pipelined divider, result stage.
// Depends on atni_pkg, atni_freq_sel and atni_div_stage.
//
//  channel   ports                                      handshake
//  input     start, busy, in_adc_value                  start & !busy
//  result    out_valid, out_nco_increment, out_selected_frequency,
//            out_exact_division                         out_valid strobe
//  config    psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// From start to out_valid an item passes three registers for frequency
// selection, one for the overflow check, eight divider stages of four
// quotient bits each, and the result register. A new item enters every
// cycle; busy is always low. Synchronous reset clears all valid bits and
// loads the register defaults. The receiver cannot stall.
module adc_to_nco_increment_unit import atni_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADC_BITS-1:0]  in_adc_value,
  output logic                 out_valid,
  output logic [23:0]          out_nco_increment,
  output logic [31:0]          out_selected_frequency,
  output logic                 out_exact_division,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [31:0] start_r, stop_r, clock_r;
  freq_item_t  fitem;
  div_item_t   div_nxt;
  div_item_t   stg [DIV_STAGES+1];
  logic [31:0] inc;
  logic        out_valid_r, exact_r;
  logic [23:0] inc_r;
  logic [31:0] freq_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      stop_r  <= '0;
      clock_r <= CLK_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_START: start_r <= pwdata;
        REG_STOP:  stop_r  <= pwdata;
        REG_CLOCK: clock_r <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_START: prdata = start_r;
      REG_STOP:  prdata = stop_r;
      REG_CLOCK: prdata = clock_r;
      default:   prdata = '0;
    endcase
  end

  atni_freq_sel #(.ADC_BITS(ADC_BITS)) u_freq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_adc  (in_adc_value),
    .start_f (start_r),
    .stop_f  (stop_r),
    .item_r  (fitem)
  );

  // The quotient exceeds 32 bits exactly when freq/2^11 reaches the divisor;
  // this also covers a zero clock. Otherwise the top 21 dividend bits are
  // below the divisor and 32 more steps give the whole quotient.
  always_comb begin
    div_nxt.vld  = fitem.vld;
    div_nxt.freq = fitem.freq;
    div_nxt.ovf  = {{PRE_BITS{1'b0}}, fitem.freq[31:PRE_BITS]} >= clock_r;
    div_nxt.rem  = {{PRE_BITS{1'b0}}, fitem.freq[31:PRE_BITS]};
    div_nxt.sh   = {fitem.freq[PRE_BITS-1:0], {INC_SHIFT{1'b0}}};
    div_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg[0] <= '0;
    end else begin
      stg[0] <= div_nxt;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    atni_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .divisor (clock_r),
      .d_i     (stg[g]),
      .d_r     (stg[g+1])
    );
  end

  assign inc = stg[DIV_STAGES].ovf ? 32'hFFFF_FFFF : stg[DIV_STAGES].quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg[DIV_STAGES].vld;
    end
    inc_r   <= inc[23:0];
    freq_r  <= stg[DIV_STAGES].freq;
    // 2^20 is a multiple of the increment only for a power of two up to 2^20.
    exact_r <= $onehot(inc) && (inc[31:INC_SHIFT] == '0);
  end

  assign out_valid              = out_valid_r;
  assign out_nco_increment      = inc_r;
  assign out_selected_frequency = freq_r;
  assign out_exact_division     = exact_r;

`ifndef ASSERT_OFF
  a_exact_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exact_division |-> $onehot(out_nco_increment))
    else $error("exact flag set for an increment that is not a power of two");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    stg[DIV_STAGES].vld && stg[DIV_STAGES].ovf |=> out_nco_increment == 24'hFF_FFFF)
    else $error("saturated increment not all ones");
`endif

endmodule

[rtl/atni_freq_sel.sv]
// Three-stage frequency selection: span decode, multiply, offset add.
// Depends on atni_pkg.
module atni_freq_sel import atni_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [ADC_BITS-1:0] in_adc,
  input  logic [31:0]         start_f,
  input  logic [31:0]         stop_f,
  output freq_item_t          item_r
);

  localparam logic [31:0] WIDE_TH = 32'hFFFF_FFFF >> ADC_BITS;

  logic                v1_r, dead1_r, wide1_r;
  logic [31:0]         mula1_r, mid1_r, start1_r;
  logic [ADC_BITS-1:0] rd1_r;
  logic                v2_r, dead2_r, wide2_r;
  logic [31:0]         prod2_r, mid2_r, start2_r;
  logic [31:0]         span, rd32, adj;
  logic [32:0]         sum;
  logic [ADC_BITS+31:0] prod;
  freq_item_t          item_nxt;

  assign span = stop_f - start_f;
  assign sum  = {1'b0, start_f} + {1'b0, stop_f};
  assign rd32 = {{(32-ADC_BITS){1'b0}}, in_adc};
  assign prod = mula1_r * rd1_r;
  assign adj  = wide2_r ? prod2_r : (prod2_r >> ADC_BITS);

  always_comb begin
    item_nxt.vld  = v2_r;
    item_nxt.freq = dead2_r ? mid2_r : start2_r + adj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      item_r <= '0;
    end else begin
      v1_r   <= in_vld;
      v2_r   <= v1_r;
      item_r <= item_nxt;
    end
    dead1_r  <= (rd32 >= DEAD_LOW) && (rd32 <= DEAD_HIGH);
    wide1_r  <= span > WIDE_TH;
    // A wide span steps by span/FS; a narrow one scales first, divides after.
    mula1_r  <= (span > WIDE_TH) ? (span >> ADC_BITS) : span;
    mid1_r   <= sum[32:1];
    start1_r <= start_f;
    rd1_r    <= in_adc;
    dead2_r  <= dead1_r;
    wide2_r  <= wide1_r;
    prod2_r  <= prod[31:0];
    mid2_r   <= mid1_r;
    start2_r <= start1_r;
  end

endmodule

[rtl/atni_div_stage.sv]
// One pipeline stage of the restoring divider, several quotient bits per stage.
// Depends on atni_pkg.
module atni_div_stage import atni_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] divisor,
  input  div_item_t   d_i,
  output div_item_t   d_r
);

  div_item_t   d_nxt;
  logic [32:0] t;

  always_comb begin
    d_nxt = d_i;
    t     = '0;
    for (int i = 0; i < STEPS_PER_STG; i++) begin
      t       = {d_nxt.rem, d_nxt.sh[31]};
      d_nxt.sh = {d_nxt.sh[30:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        d_nxt.rem = 32'(t - {1'b0, divisor});
        d_nxt.quo = {d_nxt.quo[30:0], 1'b1};
      end else begin
        d_nxt.rem = t[31:0];
        d_nxt.quo = {d_nxt.quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else begin
      d_r <= d_nxt;
    end
  end

endmodule
